// ===== sv/rgb_to_hsv_converter_assert.svh =====
// ----------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// shared assertion forms for the converter rtl
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// checked property, held off while reset is asserted
`define RHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property that also covers the reset cycles
`define RHC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// constants, codes and pipeline stage type of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 9;
    // hue ratio quotient never exceeds 60
    localparam int HUE_Q_BITS   = 6;
    localparam int DIV_STAGES   = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;

    localparam logic [HUE_BITS-1:0] HUE_RED   = HUE_BITS'(0);
    localparam logic [HUE_BITS-1:0] HUE_GREEN = HUE_BITS'(120);
    localparam logic [HUE_BITS-1:0] HUE_BLUE  = HUE_BITS'(240);
    localparam logic [HUE_BITS-1:0] HUE_WRAP  = HUE_BITS'(360);

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } t_sector;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] d;
        logic                    grey;
        t_sector                 sector;
        logic                    neg;
        logic [CHANNEL_BITS-1:0] hrem;
        logic [HUE_Q_BITS-1:0]   hsh;
        logic [CHANNEL_BITS-1:0] srem;
        logic [CHANNEL_BITS-1:0] ssh;
    } t_stage;

endpackage

// ===== sv/rhc_div_step.sv =====
// ----------------------------------------------------------------------------
// rhc_div_step
// one restoring division step: shift in a numerator bit, trial subtract
// ----------------------------------------------------------------------------
module rhc_div_step
    import rhc_pkg::*;
(
    input  logic [CHANNEL_BITS-1:0] i_rem,
    input  logic                    i_bit,
    input  logic [CHANNEL_BITS-1:0] i_den,
    output logic [CHANNEL_BITS-1:0] o_rem,
    output logic                    o_q
);

    logic [CHANNEL_BITS:0]   shifted;
    logic [CHANNEL_BITS+1:0] trial;

    assign shifted = {i_rem, i_bit};
    assign trial   = {1'b0, shifted} - {2'b00, i_den};
    assign o_q     = ~trial[CHANNEL_BITS+1];
    // remainder stays below the divisor, so it fits the channel width
    assign o_rem   = o_q ? trial[CHANNEL_BITS-1:0] : shifted[CHANNEL_BITS-1:0];

endmodule

// ===== sv/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pipelined rgb to hsv pixel conversion with bit-per-stage dividers
// ----------------------------------------------------------------------------
//  channel  dir  beat fields                                  handshake
//  pixel    in   i_red, i_green, i_blue                       i_valid / o_stall
//  hsv      out  o_hue_degrees, o_saturation, o_brightness    o_valid / i_stall
//
//  one pixel a cycle sustained while i_stall is low; a beat passes the front
//  stage, the restoring divider stages (one quotient bit each) and the output register
//  reset clears every stage valid bit and the output valid, nothing else
//  a stalled output lets empty stages keep filling; o_stall rises only
//  once every stage holds a beat
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_assert.svh"

module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [HUE_BITS-1:0]     o_hue_degrees,
    output logic [CHANNEL_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness
);

    // ------------------------------------------------------------------
    // front stage: max, difference, sector, and both dividend set-ups
    // ------------------------------------------------------------------
    logic [CHANNEL_BITS-1:0]   mx;
    logic [CHANNEL_BITS-1:0]   d;
    t_sector                   sector;
    logic                      neg;
    logic [CHANNEL_BITS-1:0]   absx;
    logic [CHANNEL_BITS:0]     d_gb;
    logic [CHANNEL_BITS:0]     d_bg;
    logic [CHANNEL_BITS:0]     d_br;
    logic [CHANNEL_BITS:0]     d_rb;
    logic [CHANNEL_BITS:0]     d_rg;
    logic [CHANNEL_BITS:0]     d_gr;
    logic [CHANNEL_BITS+5:0]   hnum;
    logic [2*CHANNEL_BITS-1:0] snum;
    t_stage                    n_front;

    always_comb begin
        // every pairwise difference side by side, the borrow bit gives the order
        d_gb = {1'b0, i_green} - {1'b0, i_blue};
        d_bg = {1'b0, i_blue}  - {1'b0, i_green};
        d_br = {1'b0, i_blue}  - {1'b0, i_red};
        d_rb = {1'b0, i_red}   - {1'b0, i_blue};
        d_rg = {1'b0, i_red}   - {1'b0, i_green};
        d_gr = {1'b0, i_green} - {1'b0, i_red};

        // red wins ties, then green
        if (!d_rg[CHANNEL_BITS] && !d_rb[CHANNEL_BITS]) begin
            sector = SEC_RED;
        end else if (!d_gb[CHANNEL_BITS]) begin
            sector = SEC_GREEN;
        end else begin
            sector = SEC_BLUE;
        end

        // max is the sector channel; spread and |hue numerator| are
        // picked straight from the pairwise differences
        unique case (sector)
            SEC_RED: begin
                mx   = i_red;
                d    = d_gb[CHANNEL_BITS] ? d_rg[CHANNEL_BITS-1:0] : d_rb[CHANNEL_BITS-1:0];
                neg  = d_gb[CHANNEL_BITS];
                absx = neg ? d_bg[CHANNEL_BITS-1:0] : d_gb[CHANNEL_BITS-1:0];
            end
            SEC_GREEN: begin
                mx   = i_green;
                d    = d_br[CHANNEL_BITS] ? d_gb[CHANNEL_BITS-1:0] : d_gr[CHANNEL_BITS-1:0];
                neg  = d_br[CHANNEL_BITS];
                absx = neg ? d_rb[CHANNEL_BITS-1:0] : d_br[CHANNEL_BITS-1:0];
            end
            SEC_BLUE: begin
                mx   = i_blue;
                d    = d_rg[CHANNEL_BITS] ? d_br[CHANNEL_BITS-1:0] : d_bg[CHANNEL_BITS-1:0];
                neg  = d_rg[CHANNEL_BITS];
                absx = neg ? d_gr[CHANNEL_BITS-1:0] : d_rg[CHANNEL_BITS-1:0];
            end
            default: begin
                mx   = '0;
                d    = '0;
                neg  = 1'b0;
                absx = '0;
            end
        endcase

        // 60 * |x| as shift and subtract
        hnum = {absx, 6'b0} - {4'b0, absx, 2'b0};
        // d * full scale as shift and subtract
        snum = {d, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, d};

        n_front.mx     = mx;
        n_front.d      = d;
        n_front.grey   = (d == '0);
        n_front.sector = sector;
        n_front.neg    = neg;
        // upper dividend bits are already below the divisor
        n_front.hrem   = hnum[CHANNEL_BITS+5:6];
        n_front.hsh    = hnum[5:0];
        n_front.srem   = snum[2*CHANNEL_BITS-1:CHANNEL_BITS];
        n_front.ssh    = snum[CHANNEL_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // pipeline registers: stage 0 is the front, stages 1..DIV_STAGES
    // each add one quotient bit to the saturation divider, and the first
    // HUE_Q_BITS of them one to the hue divider as well
    t_stage                  r_st  [0:DIV_STAGES];
    logic   [DIV_STAGES:0]   r_vld;
    t_stage                  n_st  [1:DIV_STAGES];
    logic   [DIV_STAGES:0]   en;
    logic                    en_out;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [CHANNEL_BITS-1:0] h_rem;
        logic                    h_q;
        logic [CHANNEL_BITS-1:0] s_rem;
        logic                    s_q;

        if (k < HUE_Q_BITS) begin : g_hue
            rhc_div_step u_hue (
                .i_rem (r_st[k].hrem),
                .i_bit (r_st[k].hsh[HUE_Q_BITS-1]),
                .i_den (r_st[k].d),
                .o_rem (h_rem),
                .o_q   (h_q)
            );
        end else begin : g_hue_hold
            assign h_rem = r_st[k].hrem;
            assign h_q   = 1'b0;
        end

        if (k < CHANNEL_BITS) begin : g_sat
            rhc_div_step u_sat (
                .i_rem (r_st[k].srem),
                .i_bit (r_st[k].ssh[CHANNEL_BITS-1]),
                .i_den (r_st[k].mx),
                .o_rem (s_rem),
                .o_q   (s_q)
            );
        end else begin : g_sat_hold
            assign s_rem = r_st[k].srem;
            assign s_q   = 1'b0;
        end

        always_comb begin
            n_st[k+1] = r_st[k];
            if (k < HUE_Q_BITS) begin
                n_st[k+1].hrem = h_rem;
                n_st[k+1].hsh  = {r_st[k].hsh[HUE_Q_BITS-2:0], h_q};
            end
            if (k < CHANNEL_BITS) begin
                n_st[k+1].srem = s_rem;
                n_st[k+1].ssh  = {r_st[k].ssh[CHANNEL_BITS-2:0], s_q};
            end
        end
    end

    // a stage loads when empty or when its beat moves on
    always_comb begin
        en_out = ~o_valid | ~i_stall;
        en[DIV_STAGES] = ~r_vld[DIV_STAGES] | en_out;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_stall = ~en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_st[0] <= n_front;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (en[k]) r_st[k] <= n_st[k];
        end
    end

    // ------------------------------------------------------------------
    // back stage: floor correction, sector offset, wrap, output register
    // ------------------------------------------------------------------
    t_stage                  last;
    logic [HUE_Q_BITS:0]     mag;
    logic [HUE_BITS-1:0]     base;
    logic [HUE_BITS-1:0]     n_hue;
    logic [CHANNEL_BITS-1:0] n_sat;
    logic                    r_out_vld;
    logic [HUE_BITS-1:0]     r_hue;
    logic [CHANNEL_BITS-1:0] r_sat;
    logic [CHANNEL_BITS-1:0] r_bri;

    always_comb begin
        last = r_st[DIV_STAGES];
        // floor toward minus infinity: bump the magnitude on a remainder
        mag = {1'b0, last.hsh}
            + (HUE_Q_BITS+1)'(last.neg && (last.hrem != '0));
        unique case (last.sector)
            SEC_RED:   base = last.neg ? HUE_WRAP : HUE_RED;
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = HUE_RED;
        endcase
        if (last.grey) begin
            n_hue = '0;
        end else if (last.neg) begin
            n_hue = base - HUE_BITS'(mag);
        end else begin
            n_hue = base + HUE_BITS'(mag);
        end
        // grey covers black as well
        n_sat = last.grey ? '0 : last.ssh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_bri <= last.mx;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_hue_degrees = r_hue;
    assign o_saturation  = r_sat;
    assign o_brightness  = r_bri;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RHC_ASSERT(a_hue_range, o_valid |-> (o_hue_degrees < HUE_WRAP), "hue out of range")
    `RHC_ASSERT(a_black, (o_valid && o_brightness == '0) |-> (o_saturation == '0 && o_hue_degrees == '0), "black pixel not zeroed")
    `RHC_ASSERT(a_grey_hue, (o_valid && o_saturation == '0) |-> (o_hue_degrees == '0), "unsaturated pixel has hue")
    `RHC_ASSERT(a_stall_full, o_stall |-> (o_valid && i_stall && (&r_vld)), "stall with room in pipeline")
    `RHC_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule
